// ===== design/utrf_pkg.sv =====
package utrf_pkg;

   localparam int DATA_W        = 8;
   localparam int TX_DEPTH_DFLT = 128;
   localparam int RX_DEPTH_DFLT = 128;

   typedef enum logic [1:0] {
      OP_TX_WRITE = 2'd0,
      OP_TX_READY = 2'd1,
      OP_RX_BYTE  = 2'd2,
      OP_RX_READ  = 2'd3
   } op_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

endpackage

// ===== design/utrf_ram.sv =====
module utrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/utrf_ring.sv =====
module utrf_ring
   import utrf_pkg::*;
#(
   parameter int DEPTH = TX_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_cmd_type      cmd,
   input  logic [DATA_W-1:0] wdata,
   output ring_stat_type     stat,
   output logic [DATA_W-1:0] rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      next_ptr = (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   assign stat.empty = (rd_ptr_ff == wr_ptr_ff);
   assign stat.full  = (next_ptr(wr_ptr_ff) == rd_ptr_ff);

   // push into a full ring drops the oldest entry
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (cmd.push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         if (stat.full) begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
         end
      end else if (cmd.pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   utrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (wr_ptr_ff),
      .wdata (wdata),
      .re    (cmd.pop),
      .raddr (rd_ptr_ff),
      .rdata (rdata)
   );

endmodule

// ===== design/uart_tx_rx_ring_fifo_core.sv =====
// Transmit and receive byte rings for a UART. Each request is one event (host
// write, transmitter ready, line byte, host read) and yields exactly one
// response in the cycle after its transfer; one request per cycle is taken while
// the response side does not stall, since each ring's pointers are registered
// and its store is a single-port-write RAM with a registered read. req_stall
// rises only while a response is held by rsp_stall. A ring of depth N holds
// N-1 bytes; a full transmit ring refuses host writes, a full receive ring
// overwrites its oldest byte. No clearing pass after reset.
module uart_tx_rx_ring_fifo_core
   import utrf_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DFLT,
   parameter int RX_DEPTH = RX_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [DATA_W-1:0] req_data_in,
   input  logic              req_burst_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_data_out,
   output logic              rsp_data_valid,
   output logic              rsp_write_accepted,
   output logic              rsp_oldest_dropped,
   output logic              rsp_tx_irq_enabled,
   output logic              rsp_result_last
);

   ring_cmd_type  tx_cmd, rx_cmd;
   ring_stat_type tx_stat, rx_stat;
   logic [DATA_W-1:0] tx_rdata, rx_rdata;
   logic          accept;
   op_type        op;

   logic rsp_valid_ff, rsp_valid_in;
   logic irq_ff, irq_in;
   logic data_valid_ff, data_valid_in;
   logic from_rx_ff;
   logic accepted_ff, accepted_in;
   logic dropped_ff, dropped_in;
   logic last_ff;

   assign op        = op_type'(req_opcode);
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      tx_cmd        = '0;
      rx_cmd        = '0;
      irq_in        = irq_ff;
      data_valid_in = 1'b0;
      accepted_in   = 1'b0;
      dropped_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (op)
            OP_TX_WRITE: begin
               if (!tx_stat.full) begin
                  tx_cmd.push = 1'b1;
                  irq_in      = 1'b1;
                  accepted_in = 1'b1;
               end
            end
            OP_TX_READY: begin
               if (!tx_stat.empty) begin
                  tx_cmd.pop    = 1'b1;
                  data_valid_in = 1'b1;
               end else begin
                  irq_in = 1'b0;
               end
            end
            OP_RX_BYTE: begin
               rx_cmd.push = 1'b1;
               dropped_in  = rx_stat.full;
            end
            OP_RX_READ: begin
               if (!rx_stat.empty) begin
                  rx_cmd.pop    = 1'b1;
                  data_valid_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         irq_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         irq_ff       <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_valid_ff <= data_valid_in;
         from_rx_ff    <= (op == OP_RX_READ);
         accepted_ff   <= accepted_in;
         dropped_ff    <= dropped_in;
         last_ff       <= req_burst_last;
      end
   end

   utrf_ring #(.DEPTH (TX_DEPTH)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .wdata (req_data_in),
      .stat  (tx_stat),
      .rdata (tx_rdata)
   );

   utrf_ring #(.DEPTH (RX_DEPTH)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .wdata (req_data_in),
      .stat  (rx_stat),
      .rdata (rx_rdata)
   );

   // ring read data holds until the next pop, so it stays stable under stall
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_valid     = data_valid_ff;
   assign rsp_data_out       = !data_valid_ff ? '0 : (from_rx_ff ? rx_rdata : tx_rdata);
   assign rsp_write_accepted = accepted_ff;
   assign rsp_oldest_dropped = dropped_ff;
   assign rsp_tx_irq_enabled = irq_ff;
   assign rsp_result_last    = last_ff;

endmodule

// ===== design/utrf_checker.sv =====
module utrf_checker
   import utrf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_opcode,
   input logic              req_burst_last,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_data_out,
   input logic              rsp_data_valid,
   input logic              rsp_write_accepted,
   input logic              rsp_tx_irq_enabled,
   input logic              rsp_result_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_data_valid) && $stable(rsp_result_last))
      else $error("response changed under stall");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid && (rsp_result_last == $past(req_burst_last)))
      else $error("response missing one cycle after request transfer");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_write_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_accepted |-> rsp_tx_irq_enabled && !rsp_data_valid)
      else $error("stored tx write without interrupt enable");

   a_flag_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode != OP_TX_WRITE |=> !rsp_write_accepted)
      else $error("write_accepted set for a non-write opcode");

endmodule

bind uart_tx_rx_ring_fifo_core utrf_checker u_utrf_checker (.*);
